@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/frle_pkg.sv @@
`default_nettype none
package frle_pkg;

   localparam int unsigned OFS_W     = 17;
   localparam int unsigned Q_DEPTH   = 2;
   localparam int unsigned Q_PTR_W   = 1;
   localparam int unsigned Q_CNT_W   = 2;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_DATA  = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   localparam logic CSR_START_OFFSET = 1'b0;
   localparam logic CSR_BACKGROUND   = 1'b1;

   localparam logic [7:0] RUN_FLAG  = 8'h80;
   localparam logic [6:0] VALUE_MSK = 7'h7F;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_FILL,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [6:0]   value;
      logic [7:0]   len;
   } cmd_type;

   typedef struct packed {
      logic [15:0] start_offset;
      logic        background_present;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      logic    ready;
      cmd_type cmd;
   } q_link_type;

endpackage
`default_nettype wire

@@ design/frle_intf.sv @@
`default_nettype none
interface frle_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface frle_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] run_start;
   logic [15:0] run_length;
   logic [7:0]  pixel_value;
   logic        from_background;

   modport source (output valid, output run_start, output run_length,
                   output pixel_value, output from_background, input ready);
   modport sink   (input valid, input run_start, input run_length,
                   input pixel_value, input from_background, output ready);
endinterface
`default_nettype wire

@@ design/frame_rle_run_decoder.sv @@
// An accepted item enters a two-entry command queue between the byte parser and the run
// unit; a popped command's run descriptor goes to the result register. Throughput: one item
// per cycle while the queue has room; the run unit pops only when no result is stalled.
// Reset (synchronous, active high) clears parser flags, pixel offset, frame-filled flag,
// queue pointers, result valid and both configuration registers; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module frame_rle_run_decoder #(
   parameter int unsigned FRAME_PIXELS = 64000
) (
   input  wire logic        clock,
   input  wire logic        reset,
   frle_req_if.sink         req_if,
   frle_rsp_if.source       rsp_if,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [15:0]          start_offset_ff;
   logic                 background_ff;
   frle_pkg::cfg_type    cfg;
   frle_pkg::cmd_type    push_cmd;
   logic                 push;
   logic                 pop;
   frle_pkg::q_link_type link;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_offset_ff <= 16'd0;
         background_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            frle_pkg::CSR_START_OFFSET: start_offset_ff <= csr_wdata;
            frle_pkg::CSR_BACKGROUND:   background_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.start_offset       = start_offset_ff;
   assign cfg.background_present = background_ff;

   frle_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_ready  (link.ready),
      .push_cmd (push_cmd),
      .push     (push)
   );

   frle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .link     (link)
   );

   frle_back #(
      .FRAME_PIXELS (FRAME_PIXELS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .link   (link),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

   `ASSERT_CLK(a_bg_value_zero, clock, reset, rsp_if.valid && rsp_if.from_background |-> rsp_if.pixel_value == 8'd0, "background copy with nonzero value")
   `ASSERT_CLK(a_fill_len_nonzero, clock, reset, rsp_if.valid && !rsp_if.from_background |-> rsp_if.run_length != 16'd0, "fill run of zero length")
   `ASSERT_CLK(a_run_in_frame, clock, reset, rsp_if.valid |-> (32'(rsp_if.run_start) + 32'(rsp_if.run_length)) <= 32'(FRAME_PIXELS), "run extends past frame end")
   `ASSERT_ALWAYS(a_no_pop_empty, clock, pop |-> link.valid, "run unit took a command from an empty queue")

endmodule
`default_nettype wire

@@ design/frle_front.sv @@
`default_nettype none
module frle_front (
   input  wire logic       clock,
   input  wire logic       reset,
   frle_req_if.sink        req_if,
   input  wire logic       q_ready,
   output frle_pkg::cmd_type push_cmd,
   output logic            push
);

   logic       awaiting_ff, awaiting_in;
   logic       stopped_ff,  stopped_in;
   logic [6:0] pending_ff,  pending_in;
   logic       accept;

   assign req_if.ready = q_ready;
   assign accept       = req_if.valid && q_ready;

   always_comb begin
      awaiting_in    = awaiting_ff;
      stopped_in     = stopped_ff;
      pending_in     = pending_ff;
      push           = 1'b0;
      push_cmd.kind  = frle_pkg::CMD_FILL;
      push_cmd.value = 7'd0;
      push_cmd.len   = 8'd1;
      if (accept) begin
         case (req_if.opcode)
            frle_pkg::OP_START: begin
               awaiting_in   = 1'b0;
               stopped_in    = 1'b0;
               pending_in    = 7'd0;
               push          = 1'b1;
               push_cmd.kind = frle_pkg::CMD_START;
            end
            frle_pkg::OP_DATA: begin
               if (!stopped_ff) begin
                  if (awaiting_ff) begin
                     awaiting_in = 1'b0;
                     if (req_if.data_byte == 8'd0) begin
                        stopped_in = 1'b1;
                     end else begin
                        push           = 1'b1;
                        push_cmd.value = pending_ff;
                        push_cmd.len   = req_if.data_byte;
                     end
                  end else if ((req_if.data_byte & frle_pkg::RUN_FLAG) != 8'd0) begin
                     pending_in  = req_if.data_byte[6:0] & frle_pkg::VALUE_MSK;
                     awaiting_in = 1'b1;
                  end else begin
                     push           = 1'b1;
                     push_cmd.value = req_if.data_byte[6:0];
                  end
               end
            end
            frle_pkg::OP_END: begin
               awaiting_in   = 1'b0;
               push          = 1'b1;
               push_cmd.kind = frle_pkg::CMD_END;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         stopped_ff  <= 1'b0;
         pending_ff  <= 7'd0;
      end else begin
         awaiting_ff <= awaiting_in;
         stopped_ff  <= stopped_in;
         pending_ff  <= pending_in;
      end
   end

endmodule
`default_nettype wire

@@ design/frle_queue.sv @@
`default_nettype none
module frle_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire frle_pkg::cmd_type  push_cmd,
   input  wire logic               pop,
   output frle_pkg::q_link_type    link
);

   frle_pkg::cmd_type                 entry_ff [frle_pkg::Q_DEPTH];
   logic [frle_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [frle_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [frle_pkg::Q_CNT_W-1:0]      count_ff,  count_in;
   logic                              do_push, do_pop;

   assign link.valid = count_ff != '0;
   assign link.ready = count_ff != frle_pkg::Q_CNT_W'(frle_pkg::Q_DEPTH);
   assign link.cmd   = entry_ff[rd_ptr_ff];

   assign do_push = push && link.ready;
   assign do_pop  = pop && link.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ design/frle_back.sv @@
`default_nettype none
module frle_back #(
   parameter int unsigned FRAME_PIXELS = 64000
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire frle_pkg::cfg_type    cfg,
   input  wire frle_pkg::q_link_type link,
   output logic                      pop,
   frle_rsp_if.source                rsp_if
);

   localparam int unsigned OW = frle_pkg::OFS_W;
   localparam logic [OW-1:0] FRAME_END  = OW'(FRAME_PIXELS);
   localparam logic [OW-1:0] FRAME_LAST = OW'(FRAME_PIXELS - 1);

   logic [OW-1:0] offset_ff, offset_in;
   logic          filled_ff, filled_in;
   logic          out_valid_ff, out_valid_in;
   logic [15:0]   run_start_ff, run_length_ff;
   logic [7:0]    pixel_value_ff;
   logic          from_bg_ff;

   logic          emit;
   logic [OW-1:0] e_start, e_len;
   logic [7:0]    e_value;
   logic          e_bg;
   logic [OW-1:0] start_ext, start_sat, room, fill_len, req_len, end_ofs;

   assign pop       = link.valid && (!out_valid_ff || rsp_if.ready);
   assign start_ext = OW'(cfg.start_offset);
   assign start_sat = (start_ext >= FRAME_END) ? FRAME_LAST : start_ext;
   assign room      = FRAME_END - offset_ff;
   assign req_len   = OW'(link.cmd.len);
   assign fill_len  = (req_len > room) ? room : req_len;
   assign end_ofs   = offset_ff + fill_len;

   always_comb begin
      offset_in = offset_ff;
      filled_in = filled_ff;
      emit      = 1'b0;
      e_start   = offset_ff;
      e_len     = fill_len;
      e_value   = 8'd0;
      e_bg      = 1'b0;
      if (pop) begin
         case (link.cmd.kind)
            frle_pkg::CMD_START: begin
               offset_in = start_sat;
               filled_in = 1'b0;
               emit      = cfg.background_present && (start_sat != '0);
               e_start   = '0;
               e_len     = start_sat;
               e_bg      = 1'b1;
            end
            frle_pkg::CMD_FILL: begin
               if (!filled_ff) begin
                  if (fill_len == '0) begin
                     filled_in = 1'b1;
                  end else begin
                     emit      = 1'b1;
                     offset_in = end_ofs;
                     filled_in = end_ofs >= FRAME_END;
                     if (cfg.background_present && link.cmd.value == 7'd0) begin
                        e_bg = 1'b1;
                     end else begin
                        e_value = {cfg.background_present, link.cmd.value};
                     end
                  end
               end
            end
            frle_pkg::CMD_END: begin
               emit      = !filled_ff && cfg.background_present && (offset_ff < FRAME_END);
               e_len     = room;
               e_bg      = 1'b1;
               filled_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = emit;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         run_start_ff   <= e_start[15:0];
         run_length_ff  <= e_len[15:0];
         pixel_value_ff <= e_value;
         from_bg_ff     <= e_bg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         filled_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         filled_ff    <= filled_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.run_start       = run_start_ff;
   assign rsp_if.run_length      = run_length_ff;
   assign rsp_if.pixel_value     = pixel_value_ff;
   assign rsp_if.from_background = from_bg_ff;

endmodule
`default_nettype wire
